@@ hdl/utf8d_pkg.sv @@
// utf8d_pkg: shared types and constants for the utf-8 stream decoder
// depends on nothing; used by utf8d_decode, utf8d_out_queue and the top level
package utf8d_pkg;

    localparam int CpWidth = 21;

    // replacement character and code point limits
    localparam logic [CpWidth-1:0] REPL_CP     = 21'h00FFFD;
    localparam logic [CpWidth-1:0] MIN_TWO     = 21'h000080;
    localparam logic [CpWidth-1:0] MIN_THREE   = 21'h000800;
    localparam logic [CpWidth-1:0] MIN_FOUR    = 21'h010000;
    localparam logic [CpWidth-1:0] SURR_LOW    = 21'h00D800;
    localparam logic [CpWidth-1:0] SURR_HIGH   = 21'h00DFFF;
    localparam logic [CpWidth-1:0] MAX_CP      = 21'h10FFFF;

    // one result word
    typedef struct packed {
        logic               has_code_point;
        logic [CpWidth-1:0] code_point;
        logic               text_valid;
        logic               last_result;
    } res_t;

endpackage

@@ hdl/utf8d_decode.sv @@
// utf8d_decode: decoder state registers and single-pass byte decode logic
// depends on utf8d_pkg; gives up to two result words per input byte
module utf8d_decode
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       byte_in,
    input  logic             end_of_text,
    output logic [1:0]       res_count,
    output utf8d_pkg::res_t  res0,
    output utf8d_pkg::res_t  res1
);

    typedef struct packed {
        logic                          emit;
        logic                          bad;
        logic [utf8d_pkg::CpWidth-1:0] cp;
        logic [1:0]                    due;
        logic [utf8d_pkg::CpWidth-1:0] pcp;
    } lead_t;

    // decode a byte as a lead byte, with no sequence pending or after an interrupted one
    function automatic lead_t lead_decode(input logic [7:0] b,
                                          input logic [utf8d_pkg::CpWidth-1:0] pcp);
        lead_t r;
        r.emit = 1'b0;
        r.bad  = 1'b0;
        r.cp   = '0;
        r.due  = 2'd0;
        r.pcp  = pcp;
        if (b[7] == 1'b0)
        begin
            r.emit = 1'b1;
            r.cp   = {13'd0, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            r.due = 2'd1;
            r.pcp = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            r.due = 2'd2;
            r.pcp = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            r.due = 2'd3;
            r.pcp = {18'd0, b[2:0]};
        end
        else
        begin
            r.emit = 1'b1;
            r.bad  = 1'b1;
            r.cp   = utf8d_pkg::REPL_CP;
        end
        return r;
    endfunction

    logic [utf8d_pkg::CpWidth-1:0] pcp_reg, pcp_next;
    logic [1:0]                    due_reg, due_next;
    logic [2:0]                    len_reg, len_next;
    logic                          vsf_reg, vsf_next;

    lead_t                         ld;
    logic                          is_cont;
    logic                          seq_bad;
    logic                          report;
    logic [utf8d_pkg::CpWidth-1:0] shifted;
    logic [utf8d_pkg::CpWidth-1:0] cp0, cp1;

    // next state and emitted code points
    always_comb
    begin
        pcp_next  = pcp_reg;
        due_next  = due_reg;
        len_next  = len_reg;
        vsf_next  = vsf_reg;
        res_count = 2'd0;
        cp0       = '0;
        cp1       = '0;
        seq_bad   = 1'b0;
        ld        = lead_decode(byte_in, pcp_reg);
        is_cont   = (byte_in[7:6] == 2'b10);
        shifted   = {pcp_reg[utf8d_pkg::CpWidth-7:0], byte_in[5:0]};

        if (due_reg == 2'd0)
        begin
            pcp_next = ld.pcp;
            due_next = ld.due;
            len_next = {1'b0, ld.due} + 3'd1;
            if (ld.bad)
                vsf_next = 1'b0;
            if (ld.emit)
            begin
                res_count = 2'd1;
                cp0       = ld.cp;
            end
        end
        else if (!is_cont)
        begin
            // interrupted sequence, then the byte starts over as a lead
            cp0       = utf8d_pkg::REPL_CP;
            vsf_next  = 1'b0;
            pcp_next  = ld.pcp;
            due_next  = ld.due;
            len_next  = {1'b0, ld.due} + 3'd1;
            res_count = ld.emit ? 2'd2 : 2'd1;
            cp1       = ld.cp;
        end
        else
        begin
            pcp_next = shifted;
            due_next = due_reg - 2'd1;
            if (due_next == 2'd0)
            begin
                seq_bad = (len_reg >= 3'd2 && shifted < utf8d_pkg::MIN_TWO)
                       || (len_reg >= 3'd3 && shifted < utf8d_pkg::MIN_THREE)
                       || (len_reg >= 3'd4 && shifted < utf8d_pkg::MIN_FOUR)
                       || (shifted >= utf8d_pkg::SURR_LOW
                           && shifted <= utf8d_pkg::SURR_HIGH)
                       || (shifted > utf8d_pkg::MAX_CP);
                res_count = 2'd1;
                cp0       = seq_bad ? utf8d_pkg::REPL_CP : shifted;
                if (seq_bad)
                    vsf_next = 1'b0;
                pcp_next = '0;
            end
        end

        report = vsf_next && (due_next == 2'd0);

        // end of text: the report is taken first, then the state is reset and the validity flag set again
        if (end_of_text)
        begin
            vsf_next = 1'b1;
            due_next = 2'd0;
            len_next = 3'd0;
            pcp_next = '0;
        end
    end

    // result words
    always_comb
    begin
        res0.has_code_point = 1'b1;
        res0.code_point     = cp0;
        res0.text_valid     = report;
        res0.last_result    = (res_count != 2'd2);
        res1.has_code_point = 1'b1;
        res1.code_point     = cp1;
        res1.text_valid     = report;
        res1.last_result    = 1'b1;
        if (res_count == 2'd0 && end_of_text)
        begin
            res0.has_code_point = 1'b0;
            res0.code_point     = '0;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcp_reg <= '0;
            due_reg <= 2'd0;
            len_reg <= 3'd0;
            vsf_reg <= 1'b1;
        end
        else if (step)
        begin
            pcp_reg <= pcp_next;
            due_reg <= due_next;
            len_reg <= len_next;
            vsf_reg <= vsf_next;
        end
    end

    // two results only come from an interrupted sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        res_count == 2'd2 |-> res0.code_point == utf8d_pkg::REPL_CP && due_reg != 2'd0)
        else $error("double result without interrupted sequence");

    // a pending sequence always has fewer bytes due than its length
    assert property (@(posedge clk) disable iff (!rst_n)
        due_reg != 2'd0 |-> len_reg == {1'b0, due_reg} + 3'd1 || len_reg > {1'b0, due_reg})
        else $error("pending count exceeds sequence length");

endmodule

@@ hdl/utf8d_out_queue.sv @@
// utf8d_out_queue: two-entry result register feeding the output channel
// depends on utf8d_pkg; takes up to two result words per cycle, as many as there is room for
module utf8d_out_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  utf8d_pkg::res_t  push0,
    input  utf8d_pkg::res_t  push1,
    output logic [1:0]       room,
    output logic             out_valid,
    input  logic             out_stall,
    output utf8d_pkg::res_t  head
);

    utf8d_pkg::res_t slot0_reg, slot0_next;
    utf8d_pkg::res_t slot1_reg, slot1_next;
    logic [1:0]      count_reg, count_next;
    logic            pop;
    logic [1:0]      rem_count;
    utf8d_pkg::res_t rem0;

    assign out_valid = (count_reg != 2'd0);
    assign head      = slot0_reg;
    assign pop       = out_valid && !out_stall;

    // space left once the head word, if it leaves this cycle, has gone
    always_comb
    begin
        rem_count = pop ? count_reg - 2'd1 : count_reg;
        rem0      = pop ? slot1_reg : slot0_reg;
        room      = 2'd2 - rem_count;
    end

    // shift and fill
    always_comb
    begin
        slot0_next = rem0;
        slot1_next = slot1_reg;
        if (rem_count == 2'd0)
        begin
            slot0_next = push0;
            slot1_next = push1;
        end
        else if (rem_count == 2'd1)
        begin
            slot1_next = push0;
        end
        count_next = rem_count + push_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // never more words pushed than fit
    assert property (@(posedge clk) disable iff (!rst_n)
        push_count <= room)
        else $error("result queue overflow");

    // occupancy stays within two entries
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

@@ hdl/utf8_stream_decoder_top.sv @@
// utf8_stream_decoder_top: utf-8 byte stream decoder, input register to result queue
// depends on utf8d_pkg, utf8d_decode, utf8d_out_queue
//
//  channel | handshake                  | word
//  --------+----------------------------+----------------------------------------------
//  in      | in_valid / in_stall        | byte_in, end_of_text
//  out     | out_valid / out_stall      | has_code_point, code_point, text_valid,
//          |                            | last_result
//
// one byte per cycle while in_stall is low; a byte is held in the input register
// and is decoded there straight into a two-entry result queue, whose head word
// is offered on the output and leaves the queue when out_stall is low.
// a byte that gives two words sends them one after the other through the single
// output port of the queue.
// reset clears the decoder state (validity flag set) and empties both stages.
// in_stall rises only while a decoded byte has no room in the result queue.
module utf8_stream_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        has_code_point,
    output logic [20:0] code_point,
    output logic        text_valid,
    output logic        last_result
);

    logic            in_full_reg, in_full_next;
    logic [7:0]      byte_reg;
    logic            eot_reg;
    logic            consume;
    logic            accept;
    logic [1:0]      res_count;
    logic [1:0]      word_count;
    logic [1:0]      push_count;
    logic [1:0]      room;
    utf8d_pkg::res_t res0, res1, head;

    // words the held byte needs, counting a status-only word at end of text
    assign word_count = (res_count == 2'd0 && eot_reg) ? 2'd1 : res_count;

    // input register control
    assign consume  = in_full_reg && (word_count <= room);
    assign in_stall = in_full_reg && !consume;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (accept)
            in_full_next = 1'b1;
        else if (consume)
            in_full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= byte_in;
            eot_reg  <= end_of_text;
        end
    end

    // decode
    utf8d_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (consume),
        .byte_in     (byte_reg),
        .end_of_text (eot_reg),
        .res_count   (res_count),
        .res0        (res0),
        .res1        (res1)
    );

    // words written into the queue this cycle
    assign push_count = consume ? word_count : 2'd0;

    // result queue
    utf8d_out_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .head       (head)
    );

    assign has_code_point = head.has_code_point;
    assign code_point     = head.code_point;
    assign text_valid     = head.text_valid;
    assign last_result    = head.last_result;

    // a consumed byte marked end of text always gives at least one word
    assert property (@(posedge clk) disable iff (!rst_n)
        consume && eot_reg |-> push_count != 2'd0)
        else $error("end of text without a result word");

    // stall only while a byte is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_full_reg)
        else $error("input stalled with empty register");

endmodule
